### hw/rtl/etsc_pkg.sv
// etsc_pkg: constants and tables shared by the epoch-seconds-to-calendar block.
// Used by etsc_div_step and epoch_seconds_to_calendar_top. No dependencies.
package etsc_pkg;

    localparam int SECONDS_WIDTH_DEF = 40;

    // quotient bits resolved per long-division stage
    localparam int DIV_STEP = 8;

    // seconds from 1601-01-01 to 1970-01-01
    localparam logic [63:0] REBASE_1601 = 64'd11644473600;

    // 86400 = 675 << 7: shift off seven bits, divide the rest by 675
    localparam int          DAY_SHIFT = 7;
    localparam int unsigned DAY_DIV   = 675;

    localparam int unsigned DAYS_400Y = 146097;
    localparam int unsigned DAYS_100Y = 36524;
    localparam int unsigned DAYS_4Y   = 1461;
    localparam int unsigned DAYS_1Y   = 365;

    localparam int unsigned SEC_PER_HOUR = 3600;
    localparam int unsigned SEC_PER_MIN  = 60;

    localparam int DAY_REM_W = $clog2(DAY_DIV);         // 10
    localparam int ERA_REM_W = $clog2(DAYS_400Y);       // 18
    localparam int SOD_W     = DAY_REM_W + DAY_SHIFT;   // 17, seconds of day

    // 1900 - 1601
    localparam logic [15:0] YEAR_BIAS = 16'd299;

    localparam logic [3:0] MONTH_DEC = 4'd11;

    // cumulative days before each month; row 1 is a leap year
    localparam logic [8:0] CUM_DAYS [0:1][0:12] = '{
        '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
          9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365},
        '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
          9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366}
    };

endpackage

### hw/rtl/etsc_div_step.sv
// etsc_div_step: STEP steps of restoring long division by a constant divisor.
// Combinational; depends on etsc_pkg for default parameter values.
module etsc_div_step #(
    parameter int unsigned DIVISOR = etsc_pkg::DAY_DIV,
    parameter int          REM_W   = etsc_pkg::DAY_REM_W,
    parameter int          STEP    = etsc_pkg::DIV_STEP
) (
    input  logic [REM_W-1:0] rem_in,    // must be below DIVISOR
    input  logic [STEP-1:0]  bits_in,   // next dividend bits, msb first
    output logic [STEP-1:0]  quo_out,
    output logic [REM_W-1:0] rem_out
);

    localparam logic [REM_W:0] DIV_C = (REM_W+1)'(DIVISOR);

    always_comb begin : p_div
        logic [REM_W:0] acc;
        acc     = {1'b0, rem_in};
        quo_out = '0;
        for (int i = STEP - 1; i >= 0; i--) begin
            acc = {acc[REM_W-1:0], bits_in[i]};
            if (acc >= DIV_C) begin
                acc        = acc - DIV_C;
                quo_out[i] = 1'b1;
            end
        end
        rem_out = acc[REM_W-1:0];
    end

endmodule

### hw/rtl/epoch_seconds_to_calendar_top.sv
// epoch_seconds_to_calendar_top: pipelined seconds-since-1970 to Gregorian breakdown.
// Depends on etsc_pkg and etsc_div_step.
//
// Converts one word per clock whenever s_ready is high: each s_ word is a count
// of seconds since 1970-01-01 00:00:00 (low SECONDS_WIDTH bits, 34..63) and
// produces exactly one m_ word with second, minute, hour, day of month, month
// (0 = January), year minus 1900 (low 16 bits), weekday (0 = Sunday) and day
// of year. The pipeline depth comes from two long divisions done eight quotient
// bits per stage: seconds by 86400 (as a shift by 7 and a divide by 675), then
// days by the 146097-day 400-year cycle. Each stage has a valid bit and a stage
// moves whenever the stage after it is empty or moving, so bubbles collapse and
// s_ready stays high while any stage is free, even when a result is held at the
// output.
module epoch_seconds_to_calendar_top #(
    parameter int SECONDS_WIDTH = etsc_pkg::SECONDS_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [SECONDS_WIDTH-1:0] s_epoch_seconds,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [5:0]               m_second_of_minute,
    output logic [5:0]               m_minute_of_hour,
    output logic [4:0]               m_hour_of_day,
    output logic [4:0]               m_day_of_month,
    output logic [3:0]               m_month_index,
    output logic [15:0]              m_years_since_1900,
    output logic [2:0]               m_weekday,
    output logic [8:0]               m_day_of_year
);

    // widths and stage counts
    localparam int STEP  = etsc_pkg::DIV_STEP;
    localparam int SUM_W = SECONDS_WIDTH + 1;                    // rebased seconds
    localparam int TW    = SUM_W - etsc_pkg::DAY_SHIFT;          // seconds >> 7
    localparam int NA    = (TW + STEP - 1) / STEP;               // divide-by-675 stages
    localparam int PA    = NA * STEP;
    localparam int DW    = TW - ($clog2(etsc_pkg::DAY_DIV + 1) - 1); // day count width
    localparam int NB    = (DW + STEP - 1) / STEP;               // 400-year stages
    localparam int PB    = NB * STEP;
    localparam int RA_W  = etsc_pkg::DAY_REM_W;
    localparam int RB_W  = etsc_pkg::ERA_REM_W;
    localparam int SOD_W = etsc_pkg::SOD_W;

    // stage indexes: 0 input, 1..NA day divide, NA+1..NA+NB era divide, then C..F
    localparam int KC   = NA + NB + 1;
    localparam int KD   = KC + 1;
    localparam int KE   = KC + 2;
    localparam int NSTG = KC + 4;
    localparam int KF   = NSTG - 1;

    localparam logic [RB_W-1:0] C100_1 = RB_W'(etsc_pkg::DAYS_100Y);
    localparam logic [RB_W-1:0] C100_2 = RB_W'(2 * etsc_pkg::DAYS_100Y);
    localparam logic [RB_W-1:0] C100_3 = RB_W'(3 * etsc_pkg::DAYS_100Y);
    localparam logic [10:0]     C1_1   = 11'(etsc_pkg::DAYS_1Y);
    localparam logic [10:0]     C1_2   = 11'(2 * etsc_pkg::DAYS_1Y);
    localparam logic [10:0]     C1_3   = 11'(3 * etsc_pkg::DAYS_1Y);

    // (x + 1) mod 7 of an 18-bit value; 8 = 1 mod 7, so 3-bit groups are summed
    function automatic logic [2:0] wday_of(input logic [17:0] r);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [2:0] s3;
        logic [2:0] m;
        s1 = 6'(r[2:0]) + 6'(r[5:3]) + 6'(r[8:6]) + 6'(r[11:9])
           + 6'(r[14:12]) + 6'(r[17:15]);
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = s2[2:0] + 3'(s2[3]);
        m  = (s3 == 3'd7) ? 3'd0 : s3;
        return (m == 3'd6) ? 3'd0 : 3'(m + 3'd1);
    endfunction

    //--------------------------------------------------------------------------
    // Flow control: stage k may load when some stage at or after it is empty,
    // or the output is being taken.
    //--------------------------------------------------------------------------
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [NSTG-1:0] adv;

    for (genvar k = 0; k < NSTG; k++) begin : g_adv
        assign adv[k] = m_ready | ~(&v_reg[NSTG-1:k]);
    end

    assign v_next  = {v_reg[NSTG-2:0], s_valid};
    assign s_ready = adv[0];
    assign m_valid = v_reg[KF];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    //--------------------------------------------------------------------------
    // Stage 0: rebase to 1601, split off the low seven bits of the seconds.
    //--------------------------------------------------------------------------
    logic [PA-1:0]                  wa_reg  [0:NA];   // dividend bits out, quotient in
    logic [RA_W-1:0]                ra_reg  [1:NA];
    logic [etsc_pkg::DAY_SHIFT-1:0] lo7_reg [0:NA];
    logic [SUM_W-1:0]               rebased;

    assign rebased = SUM_W'(s_epoch_seconds) + SUM_W'(etsc_pkg::REBASE_1601);

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            wa_reg[0]  <= PA'(rebased[SUM_W-1:etsc_pkg::DAY_SHIFT]);
            lo7_reg[0] <= rebased[etsc_pkg::DAY_SHIFT-1:0];
        end
    end

    //--------------------------------------------------------------------------
    // Stages 1..NA: (seconds >> 7) / 675, eight quotient bits per stage.
    //--------------------------------------------------------------------------
    for (genvar i = 1; i <= NA; i++) begin : g_a
        logic [RA_W-1:0] rem_src;
        logic [STEP-1:0] qa_bits;
        logic [RA_W-1:0] ra_next;

        if (i == 1) begin : g_first
            assign rem_src = '0;
        end else begin : g_rest
            assign rem_src = ra_reg[i-1];
        end

        etsc_div_step #(
            .DIVISOR (etsc_pkg::DAY_DIV),
            .REM_W   (RA_W),
            .STEP    (STEP)
        ) u_div (
            .rem_in  (rem_src),
            .bits_in (wa_reg[i-1][PA-1 -: STEP]),
            .quo_out (qa_bits),
            .rem_out (ra_next)
        );

        always_ff @(posedge aclk) begin
            if (adv[i]) begin
                wa_reg[i]  <= {wa_reg[i-1][PA-STEP-1:0], qa_bits};
                ra_reg[i]  <= ra_next;
                lo7_reg[i] <= lo7_reg[i-1];
            end
        end
    end

    //--------------------------------------------------------------------------
    // Stages NA+1..NA+NB: days / 146097; seconds of day ride along.
    //--------------------------------------------------------------------------
    logic [PB-1:0]    wb_reg  [1:NB];
    logic [RB_W-1:0]  rb_reg  [1:NB];
    logic [SOD_W-1:0] sod_reg [1:NB];

    for (genvar j = 1; j <= NB; j++) begin : g_b
        logic [PB-1:0]    w_src;
        logic [RB_W-1:0]  rem_src;
        logic [SOD_W-1:0] sod_src;
        logic [STEP-1:0]  qb_bits;
        logic [RB_W-1:0]  rb_next;

        if (j == 1) begin : g_first
            assign w_src   = PB'(wa_reg[NA][DW-1:0]);
            assign rem_src = '0;
            assign sod_src = {ra_reg[NA], lo7_reg[NA]};
        end else begin : g_rest
            assign w_src   = wb_reg[j-1];
            assign rem_src = rb_reg[j-1];
            assign sod_src = sod_reg[j-1];
        end

        etsc_div_step #(
            .DIVISOR (etsc_pkg::DAYS_400Y),
            .REM_W   (RB_W),
            .STEP    (STEP)
        ) u_div (
            .rem_in  (rem_src),
            .bits_in (w_src[PB-1 -: STEP]),
            .quo_out (qb_bits),
            .rem_out (rb_next)
        );

        always_ff @(posedge aclk) begin
            if (adv[NA+j]) begin
                wb_reg[j]  <= {w_src[PB-STEP-1:0], qb_bits};
                rb_reg[j]  <= rb_next;
                sod_reg[j] <= sod_src;
            end
        end
    end

    //--------------------------------------------------------------------------
    // Stage C: century within the era (clamped at 3), hour, weekday, 400*q400.
    // 146097 is a multiple of 7, so the weekday follows from the era remainder.
    //--------------------------------------------------------------------------
    logic [1:0]  c_q100_reg,  c_q100_next;
    logic [15:0] c_r100_reg,  c_r100_next;
    logic [15:0] c_ybase_reg, c_ybase_next;
    logic [4:0]  c_hour_reg,  c_hour_next;
    logic [11:0] c_rhour_reg, c_rhour_next;
    logic [2:0]  c_wday_reg,  c_wday_next;

    always_comb begin : p_stage_c
        logic [RB_W-1:0] r400;
        logic [RB_W-1:0] sub;
        r400 = rb_reg[NB];
        if (r400 >= C100_3) begin
            c_q100_next = 2'd3;
            sub         = C100_3;
        end else if (r400 >= C100_2) begin
            c_q100_next = 2'd2;
            sub         = C100_2;
        end else if (r400 >= C100_1) begin
            c_q100_next = 2'd1;
            sub         = C100_1;
        end else begin
            c_q100_next = 2'd0;
            sub         = '0;
        end
        c_r100_next  = 16'(r400 - sub);
        c_ybase_next = 16'(wb_reg[NB][15:0] * 16'd400);
        c_wday_next  = wday_of(r400);
    end

    etsc_div_step #(
        .DIVISOR (etsc_pkg::SEC_PER_HOUR),
        .REM_W   (12),
        .STEP    (5)
    ) u_hour (
        .rem_in  (sod_reg[NB][SOD_W-1:5]),
        .bits_in (sod_reg[NB][4:0]),
        .quo_out (c_hour_next),
        .rem_out (c_rhour_next)
    );

    always_ff @(posedge aclk) begin
        if (adv[KC]) begin
            c_q100_reg  <= c_q100_next;
            c_r100_reg  <= c_r100_next;
            c_ybase_reg <= c_ybase_next;
            c_hour_reg  <= c_hour_next;
            c_rhour_reg <= c_rhour_next;
            c_wday_reg  <= c_wday_next;
        end
    end

    //--------------------------------------------------------------------------
    // Stage D: 4-year groups and minutes. The century remainder tops out at
    // 36524, so the group count never exceeds 24 and needs no clamp.
    //--------------------------------------------------------------------------
    logic [4:0]  d_q4_reg,    d_q4_next;
    logic [10:0] d_r4_reg,    d_r4_next;
    logic [15:0] d_ysum_reg,  d_ysum_next;
    logic        d_cent4_reg, d_cent4_next;
    logic [4:0]  d_hour_reg;
    logic [5:0]  d_min_reg,   d_min_next;
    logic [5:0]  d_sec_reg,   d_sec_next;
    logic [2:0]  d_wday_reg;

    etsc_div_step #(
        .DIVISOR (etsc_pkg::DAYS_4Y),
        .REM_W   (11),
        .STEP    (5)
    ) u_quad (
        .rem_in  (c_r100_reg[15:5]),
        .bits_in (c_r100_reg[4:0]),
        .quo_out (d_q4_next),
        .rem_out (d_r4_next)
    );

    etsc_div_step #(
        .DIVISOR (etsc_pkg::SEC_PER_MIN),
        .REM_W   (6),
        .STEP    (6)
    ) u_min (
        .rem_in  (c_rhour_reg[11:6]),
        .bits_in (c_rhour_reg[5:0]),
        .quo_out (d_min_next),
        .rem_out (d_sec_next)
    );

    assign d_ysum_next  = 16'(c_ybase_reg + 16'(c_q100_reg) * 16'd100);
    assign d_cent4_next = (c_q100_reg == 2'd3);

    always_ff @(posedge aclk) begin
        if (adv[KD]) begin
            d_q4_reg    <= d_q4_next;
            d_r4_reg    <= d_r4_next;
            d_ysum_reg  <= d_ysum_next;
            d_cent4_reg <= d_cent4_next;
            d_hour_reg  <= c_hour_reg;
            d_min_reg   <= d_min_next;
            d_sec_reg   <= d_sec_next;
            d_wday_reg  <= c_wday_reg;
        end
    end

    //--------------------------------------------------------------------------
    // Stage E: single years (clamped at 3), day of year, leap flag, year.
    // Year mod 4 is 0 only for the fourth year of a group; the group that
    // closes a century is leap only in the fourth century of the era.
    //--------------------------------------------------------------------------
    logic [8:0]  e_yday_reg,  e_yday_next;
    logic        e_leap_reg,  e_leap_next;
    logic [15:0] e_years_reg, e_years_next;
    logic [4:0]  e_hour_reg;
    logic [5:0]  e_min_reg;
    logic [5:0]  e_sec_reg;
    logic [2:0]  e_wday_reg;

    always_comb begin : p_stage_e
        logic [1:0]  q1;
        logic [10:0] sub;
        if (d_r4_reg >= C1_3) begin
            q1  = 2'd3;
            sub = C1_3;
        end else if (d_r4_reg >= C1_2) begin
            q1  = 2'd2;
            sub = C1_2;
        end else if (d_r4_reg >= C1_1) begin
            q1  = 2'd1;
            sub = C1_1;
        end else begin
            q1  = 2'd0;
            sub = '0;
        end
        e_yday_next  = 9'(d_r4_reg - sub);
        e_leap_next  = (q1 == 2'd3) && ((d_q4_reg != 5'd24) || d_cent4_reg);
        e_years_next = 16'(d_ysum_reg + {9'd0, d_q4_reg, 2'b00} + {14'd0, q1}
                     - etsc_pkg::YEAR_BIAS);
    end

    always_ff @(posedge aclk) begin
        if (adv[KE]) begin
            e_yday_reg  <= e_yday_next;
            e_leap_reg  <= e_leap_next;
            e_years_reg <= e_years_next;
            e_hour_reg  <= d_hour_reg;
            e_min_reg   <= d_min_reg;
            e_sec_reg   <= d_sec_reg;
            e_wday_reg  <= d_wday_reg;
        end
    end

    //--------------------------------------------------------------------------
    // Stage F: month lookup against the cumulative-days row; output register.
    //--------------------------------------------------------------------------
    logic [3:0] f_month_next;
    logic [4:0] f_mday_next;

    always_comb begin : p_stage_f
        logic [8:0] row [0:12];
        logic [8:0] base;
        for (int m = 0; m < 13; m++) begin
            row[m] = etsc_pkg::CUM_DAYS[e_leap_reg][m];
        end
        f_month_next = etsc_pkg::MONTH_DEC;
        base         = row[11];
        // scan downward so the first month whose end lies past the day wins
        for (int m = 12; m >= 1; m--) begin
            if (e_yday_reg < row[m]) begin
                f_month_next = 4'(m - 1);
                base         = row[m-1];
            end
        end
        f_mday_next = 5'(e_yday_reg - base + 9'd1);
    end

    always_ff @(posedge aclk) begin
        if (adv[KF]) begin
            m_second_of_minute <= e_sec_reg;
            m_minute_of_hour   <= e_min_reg;
            m_hour_of_day      <= e_hour_reg;
            m_day_of_month     <= f_mday_next;
            m_month_index      <= f_month_next;
            m_years_since_1900 <= e_years_reg;
            m_weekday          <= e_wday_reg;
            m_day_of_year      <= e_yday_reg;
        end
    end

    //--------------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------------
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_second_of_minute < 6'd60) && (m_minute_of_hour < 6'd60)
                    && (m_hour_of_day < 5'd24))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_month_index <= etsc_pkg::MONTH_DEC) && (m_day_of_month != 5'd0)
                    && (m_weekday < 3'd7) && (m_day_of_year <= 9'd365))
        else $error("date field out of range");

    a_year_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_day_of_year == 9'd365))
            |-> (m_month_index == etsc_pkg::MONTH_DEC) && (m_day_of_month == 5'd31))
        else $error("last day of leap year not December 31");

    a_century_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[KC] |-> (c_r100_reg <= 16'(etsc_pkg::DAYS_100Y)))
        else $error("century remainder beyond one century");

    a_quad_count: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[KD] |-> (d_q4_reg <= 5'd24))
        else $error("4-year group count beyond 24");

endmodule
